/* rtl/core/range_lock_conflict_table_macros.svh */
// assertion helpers
`ifndef RANGE_LOCK_CONFLICT_TABLE_MACROS_SVH
`define RANGE_LOCK_CONFLICT_TABLE_MACROS_SVH

// same-cycle implication
`define RLCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RLCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rlct_pkg.sv */
package rlct_pkg;

   localparam int START_W  = 32;
   localparam int LEN_W    = 32;
   localparam int MODE_W   = 2;
   localparam int SEL_W    = 4;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_READ = 2'd0;

   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_COMPARE,
      ST_COMMIT
   } rlct_state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic compare;
      logic commit;
   } rlct_ctl_type;

   typedef struct packed {
      logic is_release;
   } rlct_stat_type;

endpackage

/* rtl/core/range_lock_conflict_table.sv */
// Byte-range lock table with reader/writer conflict tracking. A word is taken when start is
// high and busy is low; exactly one result word follows, shown for one cycle with rsp_strobe,
// and the receiver cannot hold it off. An acquire runs capture in the accepting cycle, then
// end-address add and free-slot search, compare against all slots in parallel, and commit;
// its strobe comes in the cycle after commit. A release skips the compare. This sequence is
// set by the controller's states. busy drops on the cycle the strobe rises, so a new word
// can be taken while the previous result is on the ports. Table depth and address width
// follow LOCK_SLOTS and ADDR_BITS; only slots below 16 can be released and reported.
module range_lock_conflict_table import rlct_pkg::*; #(
   parameter int LOCK_SLOTS = 16,
   parameter int ADDR_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [START_W-1:0]  req_range_start,
   input  logic [LEN_W-1:0]    req_range_length,
   input  logic [MODE_W-1:0]   req_access_mode,
   input  logic [SEL_W-1:0]    req_slot_select,
   output logic                rsp_strobe,
   output logic [INDEX_W-1:0]  rsp_slot_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MASK_W-1:0]   rsp_slot_mask
);

   rlct_ctl_type  ctl;
   rlct_stat_type stat;

   rlct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctl   (ctl),
      .busy  (busy)
   );

   rlct_dp #(
      .LOCK_SLOTS (LOCK_SLOTS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .req_access_mode  (req_access_mode),
      .req_slot_select  (req_slot_select),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .rsp_slot_mask    (rsp_slot_mask)
   );

endmodule

/* rtl/core/rlct_ctrl.sv */
module rlct_ctrl import rlct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  rlct_stat_type stat,
   output rlct_ctl_type  ctl,
   output logic          busy
);

`include "range_lock_conflict_table_macros.svh"

   rlct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = stat.is_release ? ST_COMMIT : ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
         end
         ST_COMPARE: begin
            ctl.compare = 1'b1;
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   `RLCT_ASSERT_NEXT(a_commit_then_idle, clock, reset, ctl.commit, !busy, "busy after commit")
   `RLCT_ASSERT_NEXT(a_load_then_prep, clock, reset, ctl.load, ctl.prep, "load not followed by prep")
   `RLCT_ASSERT_NEXT(a_compare_then_commit, clock, reset, ctl.compare, ctl.commit, "compare not followed by commit")

endmodule

/* rtl/core/rlct_dp.sv */
module rlct_dp import rlct_pkg::*; #(
   parameter int LOCK_SLOTS = 16,
   parameter int ADDR_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  rlct_ctl_type        ctl,
   output rlct_stat_type       stat,
   input  logic                req_command,
   input  logic [START_W-1:0]  req_range_start,
   input  logic [LEN_W-1:0]    req_range_length,
   input  logic [MODE_W-1:0]   req_access_mode,
   input  logic [SEL_W-1:0]    req_slot_select,
   output logic                rsp_strobe,
   output logic [INDEX_W-1:0]  rsp_slot_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MASK_W-1:0]   rsp_slot_mask
);

`include "range_lock_conflict_table_macros.svh"

   localparam int SLOT_BITS = $clog2(LOCK_SLOTS);

   logic                  cmd_ff;
   logic [ADDR_BITS-1:0]  first_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [SEL_W-1:0]      sel_ff;

   logic [ADDR_BITS-1:0]  last_ff;
   logic [SLOT_BITS-1:0]  free_slot_ff, free_slot_in;
   logic                  full_ff, full_in;
   logic [SLOT_BITS-1:0]  rel_slot_ff, rel_slot_in;
   logic                  rel_ok_ff, rel_ok_in;
   logic [LOCK_SLOTS-1:0] hit_ff, hit_in;

   logic [LOCK_SLOTS-1:0] valid_ff, valid_in;
   logic [ADDR_BITS-1:0]  efirst_ff [LOCK_SLOTS];
   logic [ADDR_BITS-1:0]  elast_ff  [LOCK_SLOTS];
   logic [MODE_W-1:0]     emode_ff  [LOCK_SLOTS];
   logic [LOCK_SLOTS-1:0] blk_ff    [LOCK_SLOTS];
   logic [LOCK_SLOTS-1:0] blk_in    [LOCK_SLOTS];

   logic [LOCK_SLOTS-1:0] rel_bit;
   logic [LOCK_SLOTS-1:0] freed;
   logic                  acq_commit;
   logic                  rel_commit;

   logic                  rsp_strobe_ff;
   logic [INDEX_W-1:0]    rsp_slot_index_ff, rsp_slot_index_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0]     rsp_slot_mask_ff, rsp_slot_mask_in;

   assign stat.is_release = (cmd_ff == CMD_RELEASE);

   // input word capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         first_ff <= ADDR_BITS'(req_range_start);
         len_ff   <= req_range_length;
         mode_ff  <= req_access_mode;
         sel_ff   <= req_slot_select;
      end
   end

   // lowest free slot
   always_comb begin
      free_slot_in = '0;
      full_in      = 1'b1;
      for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot_in = SLOT_BITS'(i);
            full_in      = 1'b0;
         end
      end
   end

   assign rel_slot_in = SLOT_BITS'(sel_ff);
   assign rel_ok_in   = (32'(sel_ff) < 32'(LOCK_SLOTS)) && valid_ff[rel_slot_in];

   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         last_ff      <= first_ff + ADDR_BITS'(len_ff) - ADDR_BITS'(1);
         free_slot_ff <= free_slot_in;
         full_ff      <= full_in;
         rel_slot_ff  <= rel_slot_in;
         rel_ok_ff    <= rel_ok_in;
      end
   end

   // overlap per slot, read/read pairs never conflict
   always_comb begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
         hit_in[i] = valid_ff[i]
            && (((efirst_ff[i] <= first_ff) && (elast_ff[i] >= first_ff))
               || ((first_ff <= efirst_ff[i]) && (last_ff >= efirst_ff[i])))
            && !((emode_ff[i] == MODE_READ) && (mode_ff == MODE_READ));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.compare) begin
         hit_ff <= hit_in;
      end
   end

   assign acq_commit = ctl.commit && (cmd_ff == CMD_ACQUIRE) && !full_ff;
   assign rel_commit = ctl.commit && (cmd_ff == CMD_RELEASE) && rel_ok_ff;
   assign rel_bit    = LOCK_SLOTS'(1) << rel_slot_ff;

   always_comb begin
      valid_in = valid_ff;
      freed    = '0;
      for (int i = 0; i < LOCK_SLOTS; i++) begin
         blk_in[i] = blk_ff[i];
         if (rel_commit && valid_ff[i] && ((blk_ff[i] & rel_bit) != '0)) begin
            blk_in[i] = blk_ff[i] & ~rel_bit;
            freed[i]  = ((blk_ff[i] & ~rel_bit) == '0);
         end
      end
      if (rel_commit) begin
         valid_in[rel_slot_ff] = 1'b0;
         blk_in[rel_slot_ff]   = '0;
      end else if (acq_commit) begin
         valid_in[free_slot_ff] = 1'b1;
         blk_in[free_slot_ff]   = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < LOCK_SLOTS; i++) begin
            blk_ff[i] <= '0;
         end
      end else if (acq_commit || rel_commit) begin
         valid_ff <= valid_in;
         for (int i = 0; i < LOCK_SLOTS; i++) begin
            blk_ff[i] <= blk_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acq_commit) begin
         efirst_ff[free_slot_ff] <= first_ff;
         elast_ff[free_slot_ff]  <= last_ff;
         emode_ff[free_slot_ff]  <= mode_ff;
      end
   end

   always_comb begin
      if (cmd_ff == CMD_ACQUIRE) begin
         if (full_ff) begin
            rsp_slot_index_in = '0;
            rsp_status_in     = STATUS_FULL;
            rsp_slot_mask_in  = '0;
         end else begin
            rsp_slot_index_in = INDEX_W'(free_slot_ff);
            rsp_status_in     = (hit_ff != '0) ? STATUS_BLOCKED : STATUS_GRANTED;
            rsp_slot_mask_in  = MASK_W'(hit_ff);
         end
      end else begin
         rsp_slot_index_in = sel_ff;
         if (rel_ok_ff) begin
            rsp_status_in    = STATUS_BLOCKED;
            rsp_slot_mask_in = MASK_W'(freed);
         end else begin
            rsp_status_in    = STATUS_EMPTY;
            rsp_slot_mask_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_slot_index_ff <= rsp_slot_index_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_slot_mask_ff  <= rsp_slot_mask_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_mask  = rsp_slot_mask_ff;

   `RLCT_ASSERT_NEXT(a_acquire_sets_valid, clock, reset, acq_commit, valid_ff[$past(free_slot_ff)], "acquired slot not valid")
   `RLCT_ASSERT_NEXT(a_release_clears_valid, clock, reset, rel_commit, !valid_ff[$past(rel_slot_ff)], "released slot still valid")
   `RLCT_ASSERT_SAME(a_granted_no_blockers, clock, reset, rsp_strobe && (rsp_status == STATUS_GRANTED), rsp_slot_mask == '0, "granted with blockers")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import rlct_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_WORDS = 1900;

   typedef struct packed {
      logic [INDEX_W-1:0]  slot_index;
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   slot_mask;
   } lock_result_type;

   // tracks the lock table and the results it owes, in acceptance order
   class lock_table_tracker;
      bit               in_use [16];
      logic [START_W-1:0] lo_addr [16];
      logic [START_W-1:0] hi_addr [16];
      logic [MODE_W-1:0]  held_mode [16];
      logic [MASK_W-1:0]  waits_on [16];
      lock_result_type  owed_results [$];
      int               failures;

      function new();
         foreach (in_use[i]) begin
            in_use[i] = 1'b0;
            waits_on[i] = '0;
         end
         failures = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void note_word(logic cmd, logic [START_W-1:0] first_addr,
                              logic [LEN_W-1:0] len, logic [MODE_W-1:0] md,
                              logic [SEL_W-1:0] sel);
         lock_result_type    r;
         logic [START_W-1:0] last_addr;
         logic [MASK_W-1:0]  hits;
         int                 slot;
         hits = '0;
         if (cmd == CMD_ACQUIRE) begin
            last_addr = first_addr + len - 1;
            slot = -1;
            for (int i = 15; i >= 0; i--)
               if (!in_use[i]) slot = i;
            if (slot < 0) begin
               r = '{'0, STATUS_FULL, '0};
            end else begin
               for (int i = 0; i < 16; i++) begin
                  if (in_use[i] &&
                      ((lo_addr[i] <= first_addr && hi_addr[i] >= first_addr) ||
                       (first_addr <= lo_addr[i] && last_addr >= lo_addr[i])) &&
                      !(held_mode[i] == MODE_READ && md == MODE_READ))
                     hits[i] = 1'b1;
               end
               in_use[slot] = 1'b1;
               lo_addr[slot] = first_addr;
               hi_addr[slot] = last_addr;
               held_mode[slot] = md;
               waits_on[slot] = hits;
               r = '{4'(slot), (hits != 0) ? STATUS_BLOCKED : STATUS_GRANTED, hits};
            end
         end else if (!in_use[sel]) begin
            r = '{sel, STATUS_EMPTY, '0};
         end else begin
            in_use[sel] = 1'b0;
            waits_on[sel] = '0;
            for (int i = 0; i < 16; i++) begin
               if (in_use[i] && waits_on[i][sel]) begin
                  waits_on[i][sel] = 1'b0;
                  if (waits_on[i] == 0) hits[i] = 1'b1;
               end
            end
            r = '{sel, STATUS_BLOCKED, hits};
         end
         owed_results.push_back(r);
      endfunction

      function void check_result(logic [INDEX_W-1:0] idx, logic [STATUS_W-1:0] st,
                                 logic [MASK_W-1:0] mask);
         lock_result_type want;
         if (owed_results.size() == 0) begin
            $error("result word with nothing outstanding: slot_index %0d status %0d", idx, st);
            failures++;
            return;
         end
         want = owed_results.pop_front();
         if (idx !== want.slot_index) begin
            $error("slot_index expected %0d actual %0d", want.slot_index, idx);
            failures++;
         end
         if (st !== want.status) begin
            $error("status expected %0d actual %0d", want.status, st);
            failures++;
         end
         if (mask !== want.slot_mask) begin
            $error("slot_mask expected %h actual %h", want.slot_mask, mask);
            failures++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_ACQUIRE;
   logic [START_W-1:0]  req_range_start = '0;
   logic [LEN_W-1:0]    req_range_length = 1;
   logic [MODE_W-1:0]   req_access_mode = MODE_READ;
   logic [SEL_W-1:0]    req_slot_select = '0;
   logic                rsp_strobe;
   logic [INDEX_W-1:0]  rsp_slot_index;
   logic [STATUS_W-1:0] rsp_status;
   logic [MASK_W-1:0]   rsp_slot_mask;
   int                  cycle_count = 0;

   lock_table_tracker book = new();

   range_lock_conflict_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .req_access_mode  (req_access_mode),
      .req_slot_select  (req_slot_select),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .rsp_slot_mask    (rsp_slot_mask)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) book.check_result(rsp_slot_index, rsp_status, rsp_slot_mask);
         if (start && !busy)
            book.note_word(req_command, req_range_start, req_range_length,
                           req_access_mode, req_slot_select);
      end
   end

   // called right after a rising edge; returns at the taking edge or later
   task automatic send_word(input logic cmd, input logic [START_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic [MODE_W-1:0] md,
                            input logic [SEL_W-1:0] sel, input int idle_pct);
      start <= 1'b1;
      req_command <= cmd;
      req_range_start <= addr;
      req_range_length <= len;
      req_access_mode <= md;
      req_slot_select <= sel;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic random_words(input int count, input int idle_pct);
      logic [START_W-1:0] addr;
      logic [LEN_W-1:0]   len;
      logic [MODE_W-1:0]  md;
      int                 acq_pct;
      acq_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) acq_pct = $urandom_range(30, 65);
         case ($urandom_range(9))
            0: begin
               addr = $urandom;
               len = $urandom;
               if (len == 0) len = 1;
            end
            1: begin
               addr = 32'hFFFF_FFFF - $urandom_range(255);
               len = $urandom_range(1, 512);
            end
            2: begin
               addr = $urandom_range(255);
               len = 32'hFFFF_FFFF - $urandom_range(3);
            end
            default: begin
               addr = $urandom_range(255);
               len = $urandom_range(1, 48);
            end
         endcase
         md = ($urandom_range(99) < 4) ? 2'd3 : 2'($urandom_range(2));
         send_word(($urandom_range(99) < acq_pct) ? CMD_ACQUIRE : CMD_RELEASE,
                   addr, len, md, 4'($urandom_range(15)), idle_pct);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single byte at zero, then a reader over all but the top byte alongside it
      send_word(CMD_ACQUIRE, 32'h0, 32'h1, MODE_READ, 4'd0, 15);
      send_word(CMD_ACQUIRE, 32'h0, 32'hFFFF_FFFF, MODE_READ, 4'd15, 15);
      // wrapped range, mode three
      send_word(CMD_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 4'd0, 15);
      send_word(CMD_ACQUIRE, 32'h10, 32'h20, 2'd1, 4'd0, 15);
      send_word(CMD_ACQUIRE, 32'h20, 32'h4, 2'd2, 4'd0, 15);
      send_word(CMD_RELEASE, 32'h0, 32'h1, MODE_READ, 4'd15, 15);
      send_word(CMD_RELEASE, 32'h0, 32'h1, MODE_READ, 4'd1, 15);
      send_word(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 4'd1, 15);
      // fill the table, last one finds it full
      for (int k = 0; k < 13; k++)
         send_word(CMD_ACQUIRE, 32'h100 + 8 * k, 32'h8, 2'(k % 3), 4'(k), 15);
      drain();

      random_words(RANDOM_WORDS / 3, 15);
      drain();
      random_words(RANDOM_WORDS / 3, 49);
      drain();
      random_words(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3), 0);
      drain();
      repeat (10) @(posedge clock);

      if (book.pending() != 0) begin
         $error("%0d result words never arrived", book.pending());
         book.failures++;
      end
      if (book.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rlct_pkg.sv
rtl/core/rlct_ctrl.sv
rtl/core/rlct_dp.sv
rtl/core/range_lock_conflict_table.sv
sim/testbench.sv
